// ===== rtl/mlu_pkg.sv =====
// Shared types and constants for the 68000 logic instruction unit.
package mlu_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [3:0] OP_OR     = 4'd0;
  localparam logic [3:0] OP_AND    = 4'd1;
  localparam logic [3:0] OP_EOR    = 4'd2;
  localparam logic [3:0] OP_NOT    = 4'd3;
  localparam logic [3:0] OP_TAS    = 4'd4;
  localparam logic [3:0] OP_OR_CCR  = 4'd5;
  localparam logic [3:0] OP_AND_CCR = 4'd6;
  localparam logic [3:0] OP_EOR_CCR = 4'd7;
  localparam logic [3:0] OP_OR_SR   = 4'd8;
  localparam logic [3:0] OP_AND_SR  = 4'd9;
  localparam logic [3:0] OP_EOR_SR  = 4'd10;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  localparam logic [15:0] SR_RESET = 16'h2700;
  localparam int unsigned SR_SUPERVISOR_BIT = 13;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_LOGIC,
    KIND_TAS,
    KIND_CCR,
    KIND_SR
  } kind_e;

  typedef enum logic [1:0] {
    FUNC_OR,
    FUNC_AND,
    FUNC_EOR,
    FUNC_NOT
  } func_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [1:0]  size;
    logic [31:0] dest_value;
    logic [31:0] source_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_back;
    logic        privilege_violation;
    logic [15:0] status_out;
  } out_item_t;

  // Decoded command handed from the front end to the execute side.
  typedef struct packed {
    kind_e       kind;
    func_e       func;
    logic [1:0]  size;
    logic [31:0] dest_value;
    logic [31:0] source_value;
  } cmd_t;

endpackage

// ===== rtl/m68k_logic_unit.sv =====
// Top level of the 68000 logic instruction unit: front end, command queue, execute side.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o    | in_item_i  (mlu_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i  | out_item_o (mlu_pkg::out_item_t)
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes through the decode register, the queue and the result register to its result.
// The status register is read and written only in the execute side, in item order.
// Reset sets SR to 0x2700 and empties every stage.
// A stalled output fills the result register, then the queue, then the decode
// register before in_ready_o drops.
module m68k_logic_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mlu_pkg::out_item_t out_item_o
);

  logic          front_valid, front_ready;
  mlu_pkg::cmd_t front_cmd;
  logic          back_valid, back_ready;
  mlu_pkg::cmd_t back_cmd;

  mlu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  mlu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  mlu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/mlu_front.sv =====
// Front end: accepts input items, decodes them and holds one decoded command.
module mlu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlu_pkg::in_item_t  in_item_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output mlu_pkg::cmd_t      cmd_o
);

  logic          valid_q, valid_d;
  mlu_pkg::cmd_t cmd_q, cmd_d;
  logic          load;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d              = cmd_q;
    cmd_d.dest_value   = in_item_i.dest_value;
    cmd_d.source_value = in_item_i.source_value;
    // Size code three behaves as long.
    cmd_d.size = (in_item_i.size == 2'd3) ? mlu_pkg::SIZE_LONG : in_item_i.size;
    case (in_item_i.operation)
      mlu_pkg::OP_OR:      begin cmd_d.kind = mlu_pkg::KIND_LOGIC; cmd_d.func = mlu_pkg::FUNC_OR;  end
      mlu_pkg::OP_AND:     begin cmd_d.kind = mlu_pkg::KIND_LOGIC; cmd_d.func = mlu_pkg::FUNC_AND; end
      mlu_pkg::OP_EOR:     begin cmd_d.kind = mlu_pkg::KIND_LOGIC; cmd_d.func = mlu_pkg::FUNC_EOR; end
      mlu_pkg::OP_NOT:     begin cmd_d.kind = mlu_pkg::KIND_LOGIC; cmd_d.func = mlu_pkg::FUNC_NOT; end
      mlu_pkg::OP_TAS:     begin cmd_d.kind = mlu_pkg::KIND_TAS;   cmd_d.func = mlu_pkg::FUNC_OR;  end
      mlu_pkg::OP_OR_CCR:  begin cmd_d.kind = mlu_pkg::KIND_CCR;   cmd_d.func = mlu_pkg::FUNC_OR;  end
      mlu_pkg::OP_AND_CCR: begin cmd_d.kind = mlu_pkg::KIND_CCR;   cmd_d.func = mlu_pkg::FUNC_AND; end
      mlu_pkg::OP_EOR_CCR: begin cmd_d.kind = mlu_pkg::KIND_CCR;   cmd_d.func = mlu_pkg::FUNC_EOR; end
      mlu_pkg::OP_OR_SR:   begin cmd_d.kind = mlu_pkg::KIND_SR;    cmd_d.func = mlu_pkg::FUNC_OR;  end
      mlu_pkg::OP_AND_SR:  begin cmd_d.kind = mlu_pkg::KIND_SR;    cmd_d.func = mlu_pkg::FUNC_AND; end
      mlu_pkg::OP_EOR_SR:  begin cmd_d.kind = mlu_pkg::KIND_SR;    cmd_d.func = mlu_pkg::FUNC_EOR; end
      default:             begin cmd_d.kind = mlu_pkg::KIND_NOP;   cmd_d.func = mlu_pkg::FUNC_OR;  end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== rtl/mlu_queue.sv =====
// Small command queue between the front end and the execute side.
module mlu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mlu_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mlu_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  mlu_pkg::cmd_t   entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/mlu_back.sv =====
// Execute side: carries out decoded commands, keeps SR and holds the result item.
module mlu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  mlu_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mlu_pkg::out_item_t out_item_o
);

  logic               out_valid_q, out_valid_d;
  mlu_pkg::out_item_t out_q, out_d;
  logic [15:0]        sr_q, sr_d;
  logic               exec;
  logic [31:0]        mask;
  logic [31:0]        low;
  logic               sign;
  logic [31:0]        src16;
  logic [31:0]        src8;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign src8        = {24'd0, cmd_i.source_value[7:0]};
  assign src16       = {16'd0, cmd_i.source_value[15:0]};

  always_comb begin
    case (cmd_i.size)
      mlu_pkg::SIZE_BYTE: mask = 32'h0000_00FF;
      mlu_pkg::SIZE_WORD: mask = 32'h0000_FFFF;
      default:            mask = 32'hFFFF_FFFF;
    endcase
    case (cmd_i.func)
      mlu_pkg::FUNC_OR:  low = (cmd_i.dest_value | cmd_i.source_value) & mask;
      mlu_pkg::FUNC_AND: low = (cmd_i.dest_value & cmd_i.source_value) & mask;
      mlu_pkg::FUNC_EOR: low = (cmd_i.dest_value ^ cmd_i.source_value) & mask;
      default:           low = (~cmd_i.dest_value) & mask;
    endcase
    case (cmd_i.size)
      mlu_pkg::SIZE_BYTE: sign = low[7];
      mlu_pkg::SIZE_WORD: sign = low[15];
      default:            sign = low[31];
    endcase
  end

  always_comb begin
    logic [31:0] sr_ext;
    sr_ext                  = {16'd0, sr_q};
    sr_d                    = sr_q;
    out_d.result            = '0;
    out_d.write_back        = 1'b0;
    out_d.privilege_violation = 1'b0;
    case (cmd_i.kind)
      mlu_pkg::KIND_LOGIC: begin
        sr_d             = {sr_q[15:4], sign, (low == '0), 2'b00};
        out_d.result     = (cmd_i.dest_value & ~mask) | low;
        out_d.write_back = 1'b1;
      end
      mlu_pkg::KIND_TAS: begin
        // Flags come from the byte as read, before bit 7 is set.
        sr_d             = {sr_q[15:4], cmd_i.dest_value[7],
                            (cmd_i.dest_value[7:0] == 8'd0), 2'b00};
        out_d.result     = {cmd_i.dest_value[31:8], 1'b1, cmd_i.dest_value[6:0]};
        out_d.write_back = 1'b1;
      end
      mlu_pkg::KIND_CCR: begin
        case (cmd_i.func)
          mlu_pkg::FUNC_OR:  sr_d = 16'(sr_ext | src8);
          mlu_pkg::FUNC_AND: sr_d = {sr_q[15:8], sr_q[7:0] & cmd_i.source_value[7:0]};
          default:           sr_d = 16'(sr_ext ^ src8);
        endcase
      end
      mlu_pkg::KIND_SR: begin
        if (!sr_q[mlu_pkg::SR_SUPERVISOR_BIT]) begin
          out_d.privilege_violation = 1'b1;
        end else begin
          case (cmd_i.func)
            mlu_pkg::FUNC_OR:  sr_d = 16'(sr_ext | src16);
            mlu_pkg::FUNC_AND: sr_d = 16'(sr_ext & src16);
            default:           sr_d = 16'(sr_ext ^ src16);
          endcase
        end
      end
      default: begin
        sr_d = sr_q;
      end
    endcase
    out_d.status_out = sr_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sr_q        <= mlu_pkg::SR_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (exec) begin
        sr_q <= sr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== tb/m68k_logic_unit_tb.sv =====
// Self-checking testbench for the 68000 logic instruction unit.
module m68k_logic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_N = 3;
  localparam logic [1:0]  SIZE_ALIAS_LONG = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  mlu_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  mlu_pkg::out_item_t out_item_o;

  logic [15:0]        status_model;
  mlu_pkg::out_item_t expected_q[$];
  int                 mismatch_count;
  int                 burst_left;
  bit                 gaps_enabled;
  int                 hold_off_left;

  m68k_logic_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Computes the result of one instruction and advances the status register copy.
  function automatic mlu_pkg::out_item_t predict_logic(input mlu_pkg::in_item_t item);
    mlu_pkg::out_item_t res;
    logic [1:0]  sz;
    logic [31:0] mask;
    logic [31:0] sign;
    logic [31:0] low;
    logic [15:0] sr;
    res = '0;
    sr = status_model;
    sz = (item.size == SIZE_ALIAS_LONG) ? mlu_pkg::SIZE_LONG : item.size;
    case (sz)
      mlu_pkg::SIZE_BYTE: begin
        mask = 32'h0000_00FF;
        sign = 32'h0000_0080;
      end
      mlu_pkg::SIZE_WORD: begin
        mask = 32'h0000_FFFF;
        sign = 32'h0000_8000;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        sign = 32'h8000_0000;
      end
    endcase
    case (item.operation)
      mlu_pkg::OP_OR, mlu_pkg::OP_AND, mlu_pkg::OP_EOR, mlu_pkg::OP_NOT: begin
        case (item.operation)
          mlu_pkg::OP_OR:  low = item.dest_value | item.source_value;
          mlu_pkg::OP_AND: low = item.dest_value & item.source_value;
          mlu_pkg::OP_EOR: low = item.dest_value ^ item.source_value;
          default:         low = ~item.dest_value;
        endcase
        low = low & mask;
        sr[FLAG_C] = 1'b0;
        sr[FLAG_V] = 1'b0;
        sr[FLAG_Z] = (low == 32'd0);
        sr[FLAG_N] = |(low & sign);
        res.result = (item.dest_value & ~mask) | low;
        res.write_back = 1'b1;
      end
      mlu_pkg::OP_TAS: begin
        // Flags come from the byte as it was before bit 7 gets set.
        sr[FLAG_C] = 1'b0;
        sr[FLAG_V] = 1'b0;
        sr[FLAG_Z] = (item.dest_value[7:0] == 8'd0);
        sr[FLAG_N] = item.dest_value[7];
        res.result = {item.dest_value[31:8], item.dest_value[7:0] | 8'h80};
        res.write_back = 1'b1;
      end
      mlu_pkg::OP_OR_CCR:  sr = sr | {8'h00, item.source_value[7:0]};
      mlu_pkg::OP_AND_CCR: sr = {sr[15:8], sr[7:0] & item.source_value[7:0]};
      mlu_pkg::OP_EOR_CCR: sr = sr ^ {8'h00, item.source_value[7:0]};
      mlu_pkg::OP_OR_SR, mlu_pkg::OP_AND_SR, mlu_pkg::OP_EOR_SR: begin
        if (!sr[mlu_pkg::SR_SUPERVISOR_BIT]) begin
          res.privilege_violation = 1'b1;
        end else begin
          case (item.operation)
            mlu_pkg::OP_OR_SR:  sr = sr | item.source_value[15:0];
            mlu_pkg::OP_AND_SR: sr = sr & item.source_value[15:0];
            default:            sr = sr ^ item.source_value[15:0];
          endcase
        end
      end
      default: ;
    endcase
    status_model = sr;
    res.status_out = sr;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s differs: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    mlu_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_item_o.result, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_item_o.result !== want.result)
            report_mismatch("result", out_item_o.result, want.result);
          if (out_item_o.write_back !== want.write_back)
            report_mismatch("write_back", 32'(out_item_o.write_back),
                            32'(want.write_back));
          if (out_item_o.privilege_violation !== want.privilege_violation)
            report_mismatch("privilege_violation", 32'(out_item_o.privilege_violation),
                            32'(want.privilege_violation));
          if (out_item_o.status_out !== want.status_out)
            report_mismatch("status_out", 32'(out_item_o.status_out),
                            32'(want.status_out));
        end
      end
      if (in_valid_i && in_ready_o) expected_q.push_back(predict_logic(in_item_i));
    end
  end

  // Output side: stalls in stretches of random character, or holds off on request.
  initial begin
    int stall_mode;
    int mode_left;
    out_ready_i = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 40);
        end
        mode_left--;
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_item(input mlu_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_item_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic mlu_pkg::in_item_t make_item(input logic [3:0] op,
                                                  input logic [1:0] sz,
                                                  input logic [31:0] dst,
                                                  input logic [31:0] src);
    mlu_pkg::in_item_t item;
    item.operation = op;
    item.size = sz;
    item.dest_value = dst;
    item.source_value = src;
    return item;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return {16'($urandom_range(0, 65535)), 16'h0000};
      4:       return {24'h0, 8'($urandom_range(0, 255))};
      default: return $urandom;
    endcase
  endfunction

  // While supervisor mode is to be kept, SR writes leave bit 13 set.
  function automatic mlu_pkg::in_item_t rand_item(input bit keep_supervisor);
    mlu_pkg::in_item_t item;
    if ($urandom_range(0, 15) == 0) item.operation = 4'($urandom_range(11, 15));
    else item.operation = 4'($urandom_range(0, 10));
    item.size = 2'($urandom_range(0, 3));
    item.dest_value = rand_operand();
    item.source_value = rand_operand();
    if (keep_supervisor) begin
      if (item.operation == mlu_pkg::OP_AND_SR)
        item.source_value[mlu_pkg::SR_SUPERVISOR_BIT] = 1'b1;
      if (item.operation == mlu_pkg::OP_EOR_SR)
        item.source_value[mlu_pkg::SR_SUPERVISOR_BIT] = 1'b0;
    end
    return item;
  endfunction

  task automatic test_logic_ops();
    send_item(make_item(mlu_pkg::OP_OR,  mlu_pkg::SIZE_BYTE, 32'hFFFF_FF00, 32'hFFFF_FF00));
    send_item(make_item(mlu_pkg::OP_OR,  mlu_pkg::SIZE_WORD, 32'h0000_0000, 32'hFFFF_8000));
    send_item(make_item(mlu_pkg::OP_AND, mlu_pkg::SIZE_WORD, 32'hFFFF_FFFF, 32'h0000_8000));
    send_item(make_item(mlu_pkg::OP_AND, mlu_pkg::SIZE_LONG, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(make_item(mlu_pkg::OP_EOR, mlu_pkg::SIZE_LONG, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(make_item(mlu_pkg::OP_EOR, mlu_pkg::SIZE_BYTE, 32'h1234_56AA, 32'hFFFF_FF2A));
    send_item(make_item(mlu_pkg::OP_NOT, mlu_pkg::SIZE_BYTE, 32'hFFFF_FF00, 32'hFFFF_FFFF));
    send_item(make_item(mlu_pkg::OP_NOT, SIZE_ALIAS_LONG, 32'hFFFF_FFFF, 32'h0000_0000));
  endtask

  task automatic test_tas();
    send_item(make_item(mlu_pkg::OP_TAS, mlu_pkg::SIZE_LONG, 32'h1234_5600, 32'hFFFF_FFFF));
    send_item(make_item(mlu_pkg::OP_TAS, mlu_pkg::SIZE_WORD, 32'hFFFF_FFFF, 32'h0000_0000));
  endtask

  task automatic test_ccr_forms();
    send_item(make_item(mlu_pkg::OP_OR_CCR,  mlu_pkg::SIZE_LONG, 32'hFFFF_FFFF,
                        32'hFFFF_FF1F));
    send_item(make_item(mlu_pkg::OP_AND_CCR, mlu_pkg::SIZE_BYTE, 32'h0000_0000,
                        32'h0000_FF10));
    send_item(make_item(mlu_pkg::OP_EOR_CCR, mlu_pkg::SIZE_WORD, 32'hFFFF_FFFF,
                        32'hFFFF_00FF));
  endtask

  task automatic test_sr_forms();
    send_item(make_item(mlu_pkg::OP_OR_SR,  mlu_pkg::SIZE_BYTE, 32'hFFFF_FFFF,
                        32'hFFFF_8000));
    send_item(make_item(mlu_pkg::OP_AND_SR, mlu_pkg::SIZE_LONG, 32'h0000_0000,
                        32'h0000_A7FF));
    send_item(make_item(mlu_pkg::OP_EOR_SR, mlu_pkg::SIZE_WORD, 32'hFFFF_FFFF,
                        32'hFFFF_0715));
  endtask

  task automatic test_undefined_ops();
    for (int op = 11; op <= 15; op++)
      send_item(make_item(4'(op), 2'(op), 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_supervisor(input int count);
    repeat (count) send_item(rand_item(1'b1));
  endtask

  // The output holds off long enough for every stage to fill and the input to stall.
  task automatic test_backpressure();
    gaps_enabled = 1'b0;
    hold_off_left = 60;
    repeat (30) send_item(rand_item(1'b1));
    gaps_enabled = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_item(rand_item(1'b1));
    wait_for_drain();
    repeat (20) send_item(rand_item(1'b1));
  endtask

  // Leaving supervisor mode cannot be undone without a reset, so this runs last.
  task automatic test_user_mode(input int count);
    send_item(make_item(mlu_pkg::OP_AND_SR, mlu_pkg::SIZE_LONG, 32'h0, 32'hDFFF));
    send_item(make_item(mlu_pkg::OP_OR_SR,  mlu_pkg::SIZE_BYTE, 32'h0, 32'hFFFF_FFFF));
    send_item(make_item(mlu_pkg::OP_AND_SR, mlu_pkg::SIZE_WORD, 32'h0, 32'h0000_0000));
    send_item(make_item(mlu_pkg::OP_EOR_SR, mlu_pkg::SIZE_LONG, 32'h0, 32'hFFFF_FFFF));
    repeat (count) send_item(rand_item(1'b0));
  endtask

  initial begin
    mismatch_count = 0;
    burst_left = 0;
    gaps_enabled = 1'b1;
    hold_off_left = 0;
    status_model = mlu_pkg::SR_RESET;
    in_valid_i = 1'b0;
    in_item_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_logic_ops();
    test_tas();
    test_ccr_forms();
    test_sr_forms();
    test_undefined_ops();
    test_random_supervisor(280);
    test_backpressure();
    test_drain_pause();
    test_user_mode(100);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results still missing", 32'(expected_q.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
